@@ rtl/pab_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Polygon area and bounds: shared package
// Field widths, default sizes and the control structs that travel between the
// top level and the cross-term pipeline.
// ----------------------------------------------------------------------------
package pab_pkg;

  // Field widths of the input and result transactions.
  localparam int COORD_W  = 16;
  localparam int AREA_W   = 43;
  localparam int VCOUNT_W = 11;

  // Width of one coordinate product and of one vertex's combined cross terms.
  localparam int PROD_W = 2 * COORD_W;
  localparam int TERM_W = PROD_W + 3;

  // Default limit on vertices per polygon.
  localparam int MAX_VERTICES_DEF = 1024;

  // Packed widths of the stream data buses.
  localparam int IN_DATA_W  = 2 * COORD_W;
  localparam int OUT_BITS   = AREA_W + 4 * COORD_W + VCOUNT_W + 1;
  localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

  typedef logic signed [COORD_W-1:0] coord_t;

  // Pipeline control for one vertex in flight.
  typedef struct packed {
    logic valid;   // stage holds a vertex
    logic last;    // vertex closes the polygon
    logic open;    // a polygon was already open, so a previous vertex exists
  } pab_ctl_t;

  // Bounding box snapshot.
  typedef struct packed {
    coord_t min_x;
    coord_t max_x;
    coord_t min_y;
    coord_t max_y;
  } pab_box_t;

endpackage

@@ rtl/pab_cross.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Polygon area and bounds: cross-term pipeline
// Two stages. The first registers the four coordinate products, the second
// folds them into the vertex's shoelace contribution: the term from the
// previous vertex and, on the closing vertex, the term back to the first one.
// ----------------------------------------------------------------------------
module pab_cross (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               en,
  input  pab_pkg::pab_ctl_t                  in_ctl,
  input  pab_pkg::coord_t                    cur_x,
  input  pab_pkg::coord_t                    cur_y,
  input  pab_pkg::coord_t                    prev_x,
  input  pab_pkg::coord_t                    prev_y,
  input  pab_pkg::coord_t                    first_x,
  input  pab_pkg::coord_t                    first_y,
  output pab_pkg::pab_ctl_t                  out_ctl,
  output logic signed [pab_pkg::TERM_W-1:0]  out_term
);
  import pab_pkg::*;

  pab_ctl_t                  b_ctl_r;
  logic signed [PROD_W-1:0]  p_prev_a_r, p_prev_b_r, p_close_a_r, p_close_b_r;
  logic signed [PROD_W-1:0]  p_prev_a_nxt, p_prev_b_nxt, p_close_a_nxt, p_close_b_nxt;
  pab_ctl_t                  c_ctl_r;
  logic signed [TERM_W-1:0]  c_term_r, c_term_nxt;

  // Products; the previous-vertex pair only counts once a polygon is open,
  // the closing pair only on the last vertex.
  always_comb begin
    p_prev_a_nxt  = '0;
    p_prev_b_nxt  = '0;
    p_close_a_nxt = '0;
    p_close_b_nxt = '0;
    if (in_ctl.open) begin
      p_prev_a_nxt = prev_x * cur_y;
      p_prev_b_nxt = cur_x * prev_y;
    end
    if (in_ctl.last) begin
      p_close_a_nxt = cur_x * first_y;
      p_close_b_nxt = first_x * cur_y;
    end
  end

  // Combined contribution of one vertex.
  assign c_term_nxt = (TERM_W'(p_prev_a_r) - TERM_W'(p_prev_b_r))
                    + (TERM_W'(p_close_a_r) - TERM_W'(p_close_b_r));

  // Stage valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_ctl_r <= '0;
      c_ctl_r <= '0;
    end else if (en) begin
      b_ctl_r <= in_ctl;
      c_ctl_r <= b_ctl_r;
    end
  end

  // Stage payload.
  always_ff @(posedge clk) begin
    if (en) begin
      p_prev_a_r  <= p_prev_a_nxt;
      p_prev_b_r  <= p_prev_b_nxt;
      p_close_a_r <= p_close_a_nxt;
      p_close_b_r <= p_close_b_nxt;
      c_term_r    <= c_term_nxt;
    end
  end

  assign out_ctl  = c_ctl_r;
  assign out_term = c_term_r;

endmodule

@@ rtl/polygon_area_and_bounds.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Polygon area and bounds
// Streams polygon vertices (signed Q8.8) and, on the closing vertex, returns
// the shoelace signed area with 17 fractional bits, the bounding box, the
// vertex count and a count overflow flag.
//
//   Channel | Direction | Carries
//   --------+-----------+---------------------------------------------------
//   in_     | input     | one vertex per transaction, tlast closes polygon
//   out_    | output    | one polygon result per closing vertex
//
// One vertex is accepted per clock while input ready is high. A result is
// built from its closing vertex in the input register, loaded at the accepting
// edge, then the product register, the term register and the accumulate into
// the output register. Synchronous active-low reset empties the pipeline and
// closes any open polygon. An output register plus a skid register decouple
// the sides; input ready drops only while the skid register is occupied, and
// then the whole pipeline holds.
// ----------------------------------------------------------------------------
module polygon_area_and_bounds #(
  parameter int MAX_VERTICES = pab_pkg::MAX_VERTICES_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // vertex_x [15:0], vertex_y [31:16]
  input  logic [pab_pkg::IN_DATA_W-1:0]     in_tdata,
  input  logic                              in_tlast,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // signed_area [42:0], box_min_x [58:43], box_max_x [74:59],
  // box_min_y [90:75], box_max_y [106:91], vertex_count [117:107],
  // count_overflow [118], zero pad [119]
  output logic [pab_pkg::OUT_DATA_W-1:0]    out_tdata,
  output logic                              out_tvalid,
  input  logic                              out_tready
);
  import pab_pkg::*;

  localparam int CNT_W = $clog2(MAX_VERTICES + 1);

  // Polygon state.
  logic                      en;
  logic                      accept;
  coord_t                    in_x, in_y;
  coord_t                    first_x_r, first_y_r, first_x_nxt, first_y_nxt;
  coord_t                    prev_x_r, prev_y_r;
  pab_box_t                  box_r, box_nxt;
  logic [CNT_W-1:0]          cnt_r, cnt_nxt;
  logic                      ovf_r, ovf_nxt;
  logic                      open;
  logic [CNT_W+VCOUNT_W-1:0] cnt_ext;

  // Stage A (input register) and sidecar through the pipeline.
  pab_ctl_t                  a_ctl_r;
  coord_t                    a_x_r, a_y_r, a_prev_x_r, a_prev_y_r, a_first_x_r, a_first_y_r;
  pab_box_t                  a_box_r, b_box_r, c_box_r;
  logic [VCOUNT_W-1:0]       a_cnt_r, b_cnt_r, c_cnt_r;
  logic                      a_ovf_r, b_ovf_r, c_ovf_r;

  // Cross-term pipeline output and accumulator.
  pab_ctl_t                  c_ctl;
  logic signed [TERM_W-1:0]  c_term;
  logic signed [AREA_W-1:0]  sum_r, sum_nxt, sum_add;

  // Result buffering.
  logic [OUT_DATA_W-1:0]     res_word;
  logic [OUT_DATA_W-1:0]     out_data_r, out_data_nxt, skid_data_r, skid_data_nxt;
  logic                      out_valid_r, out_valid_nxt, skid_valid_r, skid_valid_nxt;
  logic                      push, pop;

  assign en        = !skid_valid_r;
  assign in_tready = en;
  assign accept    = in_tvalid && in_tready;
  assign in_x      = coord_t'(in_tdata[COORD_W-1:0]);
  assign in_y      = coord_t'(in_tdata[2*COORD_W-1:COORD_W]);
  assign open      = (cnt_r != '0);

  // Box, first vertex and count after this vertex.
  always_comb begin
    if (!open) begin
      first_x_nxt = in_x;
      first_y_nxt = in_y;
      box_nxt     = '{min_x: in_x, max_x: in_x, min_y: in_y, max_y: in_y};
    end else begin
      first_x_nxt = first_x_r;
      first_y_nxt = first_y_r;
      box_nxt     = box_r;
      if (in_x < box_r.min_x) box_nxt.min_x = in_x;
      if (in_x > box_r.max_x) box_nxt.max_x = in_x;
      if (in_y < box_r.min_y) box_nxt.min_y = in_y;
      if (in_y > box_r.max_y) box_nxt.max_y = in_y;
    end
    if (cnt_r < CNT_W'(MAX_VERTICES)) begin
      cnt_nxt = cnt_r + CNT_W'(1);
      ovf_nxt = ovf_r;
    end else begin
      cnt_nxt = cnt_r;
      ovf_nxt = 1'b1;
    end
  end

  assign cnt_ext = (CNT_W + VCOUNT_W)'(cnt_nxt);

  // Polygon state; a closing vertex returns everything to the empty polygon.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_x_r <= '0;
      first_y_r <= '0;
      prev_x_r  <= '0;
      prev_y_r  <= '0;
      box_r     <= '0;
      cnt_r     <= '0;
      ovf_r     <= 1'b0;
    end else if (accept) begin
      if (in_tlast) begin
        first_x_r <= '0;
        first_y_r <= '0;
        prev_x_r  <= '0;
        prev_y_r  <= '0;
        box_r     <= '0;
        cnt_r     <= '0;
        ovf_r     <= 1'b0;
      end else begin
        first_x_r <= first_x_nxt;
        first_y_r <= first_y_nxt;
        prev_x_r  <= in_x;
        prev_y_r  <= in_y;
        box_r     <= box_nxt;
        cnt_r     <= cnt_nxt;
        ovf_r     <= ovf_nxt;
      end
    end
  end

  // Input register valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_ctl_r <= '0;
    end else if (en) begin
      a_ctl_r <= '{valid: accept, last: in_tlast, open: open};
    end
  end

  // Input register payload and the result sidecar.
  always_ff @(posedge clk) begin
    if (en) begin
      a_x_r       <= in_x;
      a_y_r       <= in_y;
      a_prev_x_r  <= prev_x_r;
      a_prev_y_r  <= prev_y_r;
      a_first_x_r <= first_x_nxt;
      a_first_y_r <= first_y_nxt;
      a_box_r     <= box_nxt;
      a_cnt_r     <= cnt_ext[VCOUNT_W-1:0];
      a_ovf_r     <= ovf_nxt;
      b_box_r     <= a_box_r;
      b_cnt_r     <= a_cnt_r;
      b_ovf_r     <= a_ovf_r;
      c_box_r     <= b_box_r;
      c_cnt_r     <= b_cnt_r;
      c_ovf_r     <= b_ovf_r;
    end
  end

  pab_cross u_cross (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_ctl  (a_ctl_r),
    .cur_x   (a_x_r),
    .cur_y   (a_y_r),
    .prev_x  (a_prev_x_r),
    .prev_y  (a_prev_y_r),
    .first_x (a_first_x_r),
    .first_y (a_first_y_r),
    .out_ctl (c_ctl),
    .out_term(c_term)
  );

  // Running cross sum; it wraps modulo 2^43 and restarts after a closing vertex.
  assign sum_add = sum_r + AREA_W'(c_term);
  assign push    = en && c_ctl.valid && c_ctl.last;

  always_comb begin
    sum_nxt = sum_r;
    if (en && c_ctl.valid) begin
      sum_nxt = c_ctl.last ? '0 : sum_add;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
    end else begin
      sum_r <= sum_nxt;
    end
  end

  // Pack the result transaction.
  assign res_word = OUT_DATA_W'({c_ovf_r, c_cnt_r, c_box_r.max_y, c_box_r.min_y,
                                 c_box_r.max_x, c_box_r.min_x, sum_add});

  // Output register with a skid register behind it.
  assign pop = out_valid_r && out_tready;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    out_data_nxt   = out_data_r;
    skid_data_nxt  = skid_data_r;
    if (skid_valid_r) begin
      if (pop) begin
        out_data_nxt   = skid_data_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (push) begin
      if (!out_valid_r || pop) begin
        out_data_nxt  = res_word;
        out_valid_nxt = 1'b1;
      end else begin
        skid_data_nxt  = res_word;
        skid_valid_nxt = 1'b1;
      end
    end else if (pop) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule
